// ===== hdl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the sync frame deframer
// Marker codes, sequence byte layout, frame event and counter bundles.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0] MARK_FIRST  = 8'hAA;
    localparam logic [7:0] MARK_SECOND = 8'h55;
    localparam logic [7:0] SEQ_MASK    = 8'h7F;
    localparam logic [7:0] OVR_BIT     = 8'h80;

    localparam int MAX_CHANNELS = 4;
    localparam int SEQ_W        = 7;
    localparam int CNT_W        = 32;
    localparam int PADDR_W      = 3;

    typedef logic [15:0]      t_word;
    typedef logic [SEQ_W-1:0] t_seq;
    typedef logic [CNT_W-1:0] t_count;

    // one completed frame, as seen by the statistics block
    typedef struct packed {
        logic emit;
        logic synced;
        logic bad;
        logic ovr;
        t_seq seq;
    } t_frame_evt;

    typedef struct packed {
        t_count frames;
        t_count lost;
        t_count cksum_err;
        t_count overruns;
    } t_counts;

    function automatic t_count sat_add(input t_count a, input t_seq b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W + 1 - SEQ_W){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== hdl/sfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_parser: byte parser for marker framed and raw frames
// Hunts the marker, collects sequence, payload and checksum bytes.
// ----------------------------------------------------------------------------
module sfd_parser import sfd_pkg::*; #(
    parameter int CHANNELS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_sync_mode,
    input  logic       i_restart,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    output t_frame_evt o_evt,
    output t_word      o_chan [MAX_CHANNELS]
);

    localparam int PAY_LEN = 2 * CHANNELS;
    localparam int IDX_W   = (PAY_LEN > 1) ? $clog2(PAY_LEN) : 1;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_MARK = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [3:0] POS_RAW_LAST = 4'(PAY_LEN - 1);
    localparam logic [3:0] POS_PAY_LAST = 4'(PAY_LEN);
    localparam logic [3:0] POS_CKSUM    = 4'(PAY_LEN + 1);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_pos,   n_pos;
    logic [7:0] r_xor,   n_xor;
    logic [7:0] r_seqb,  n_seqb;
    logic [7:0] r_pay [PAY_LEN];
    logic [7:0] n_pay [PAY_LEN];
    logic [3:0] body_idx;

    assign body_idx = r_pos - 4'd1;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_xor   = r_xor;
        n_seqb  = r_seqb;
        n_pay   = r_pay;
        o_evt   = '0;
        if (!i_sync_mode) begin
            n_pay[r_pos[IDX_W-1:0]] = i_byte;
            if (r_pos == POS_RAW_LAST) begin
                n_pos      = 4'd0;
                o_evt.emit = 1'b1;
            end else begin
                n_pos = r_pos + 4'd1;
            end
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == MARK_FIRST) n_phase = PH_MARK;
                end
                PH_MARK: begin
                    if (i_byte == MARK_SECOND) begin
                        n_phase = PH_BODY;
                        n_pos   = 4'd0;
                        n_xor   = 8'd0;
                    end else if (i_byte != MARK_FIRST) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (r_pos == 4'd0) begin
                        n_seqb = i_byte;
                        n_xor  = i_byte;
                        n_pos  = 4'd1;
                    end else if (r_pos <= POS_PAY_LAST) begin
                        n_pay[body_idx[IDX_W-1:0]] = i_byte;
                        n_xor = r_xor ^ i_byte;
                        n_pos = r_pos + 4'd1;
                    end else begin
                        // checksum byte closes the frame, good or bad
                        o_evt.emit   = 1'b1;
                        o_evt.synced = 1'b1;
                        o_evt.bad    = (r_xor != i_byte);
                        o_evt.ovr    = |(r_seqb & OVR_BIT);
                        o_evt.seq    = SEQ_W'(r_seqb & SEQ_MASK);
                        n_phase      = PH_HUNT;
                        n_pos        = 4'd0;
                        n_xor        = 8'd0;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_pos   = 4'd0;
                    n_xor   = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= 4'd0;
            r_xor   <= 8'd0;
            r_seqb  <= 8'd0;
        end else if (i_restart) begin
            r_phase <= PH_HUNT;
            r_pos   <= 4'd0;
            r_xor   <= 8'd0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_xor   <= n_xor;
            r_seqb  <= n_seqb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && !i_restart) r_pay <= n_pay;
    end

    // channel words come from the updated payload so a raw frame sees its last byte
    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_chan
        if (c < CHANNELS) begin : g_used
            assign o_chan[c] = {n_pay[2*c+1], n_pay[2*c]};
        end else begin : g_unused
            assign o_chan[c] = '0;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CKSUM)
        else $error("byte position ran past the checksum slot");

    a_sync_emit_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.emit && i_sync_mode) |-> (r_phase == PH_BODY && r_pos == POS_CKSUM))
        else $error("synced frame closed outside the checksum slot");

endmodule

// ===== hdl/sfd_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_stats: running frame statistics
// Saturating counters and sequence gap tracking, updated once per frame.
// ----------------------------------------------------------------------------
module sfd_stats import sfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_frame_evt i_evt,
    output t_counts    o_counts
);

    t_counts r_counts, n_counts;
    t_seq    r_prev, n_prev;
    logic    r_seen, n_seen;
    t_seq    expected;
    t_seq    gap;

    assign expected = r_prev + SEQ_W'(1);
    assign gap      = i_evt.seq - expected;

    always_comb begin
        n_counts = r_counts;
        n_prev   = r_prev;
        n_seen   = r_seen;
        if (i_evt.ovr) n_counts.overruns = sat_add(r_counts.overruns, SEQ_W'(1));
        if (i_evt.bad) begin
            n_counts.cksum_err = sat_add(r_counts.cksum_err, SEQ_W'(1));
        end else begin
            n_counts.frames = sat_add(r_counts.frames, SEQ_W'(1));
            if (i_evt.synced) begin
                // first good frame sets the history only
                if (r_seen) n_counts.lost = sat_add(r_counts.lost, gap);
                n_prev = i_evt.seq;
                n_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
            r_prev   <= '0;
            r_seen   <= 1'b0;
        end else if (i_fire) begin
            r_counts <= n_counts;
            r_prev   <= n_prev;
            r_seen   <= n_seen;
        end
    end

    assign o_counts = r_counts;

endmodule

// ===== hdl/sync_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_deframer: marker framed, XOR checksummed sample deframer
// Parses received bytes into frames of channel words with running stats.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | i_valid / o_ready   | i_rx_byte
//   output  | o_valid / i_ready   | o_status .. o_overrun_total
//   config  | psel/penable/pready | paddr, pwdata, prdata (sync_mode at 0x0)
//
// One byte per cycle unless a held result stalls: a byte waits in the input
// register, the parser and counter update run from that register, and a
// finished frame lands in the result register.
// Reset clears parser state, counters and sequence history; sync mode is on.
// A held result stalls only the byte that closes the next frame; other bytes
// keep flowing. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sync_frame_deframer import sfd_pkg::*; #(
    parameter int CHANNELS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    // frame output
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_status,
    output logic               o_overrun_flag,
    output logic [6:0]         o_sequence_res,
    output logic [15:0]        o_channel_0,
    output logic [15:0]        o_channel_1,
    output logic [15:0]        o_channel_2,
    output logic [15:0]        o_channel_3,
    output logic [31:0]        o_frames_total,
    output logic [31:0]        o_lost_total,
    output logic [31:0]        o_checksum_error_total,
    output logic [31:0]        o_overrun_total,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       r_sync_mode;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       r_status;
    logic       r_ovr;
    t_seq       r_seq;
    t_word      r_chan [MAX_CHANNELS];

    logic       cfg_wr;
    logic       sel_mode;
    logic       out_free;
    logic       advance;
    logic       fire;
    t_frame_evt evt;
    t_word      chan [MAX_CHANNELS];
    t_counts    counts;

    // configuration: one register at word 0, anything above is ignored
    assign pready   = 1'b1;
    assign sel_mode = (paddr[PADDR_W-1:2] == '0);
    assign cfg_wr   = psel && penable && pwrite && pready && sel_mode;
    assign prdata   = sel_mode ? {31'd0, r_sync_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_mode <= 1'b1;
        end else if (cfg_wr) begin
            r_sync_mode <= pwdata[0];
        end
    end

    // hold a frame-closing byte only while the result slot is still full
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!evt.emit || out_free);
    assign fire     = advance && evt.emit;
    assign o_ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in_byte <= i_rx_byte;
    end

    sfd_parser #(
        .CHANNELS   (CHANNELS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sync_mode (r_sync_mode),
        .i_restart   (cfg_wr),
        .i_advance   (advance),
        .i_byte      (r_in_byte),
        .o_evt       (evt),
        .o_chan      (chan)
    );

    sfd_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_evt    (evt),
        .o_counts (counts)
    );

    // result register; counters change only when a frame loads here,
    // so they drive the ports straight from the stats block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= evt.bad;
            r_ovr    <= evt.ovr;
            r_seq    <= evt.seq;
            r_chan   <= chan;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_status               = r_status;
    assign o_overrun_flag         = r_ovr;
    assign o_sequence_res         = r_seq;
    assign o_channel_0            = r_chan[0];
    assign o_channel_1            = r_chan[1];
    assign o_channel_2            = r_chan[2];
    assign o_channel_3            = r_chan[3];
    assign o_frames_total         = counts.frames;
    assign o_lost_total           = counts.lost;
    assign o_checksum_error_total = counts.cksum_err;
    assign o_overrun_total        = counts.overruns;

    a_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> $stable(counts))
        else $error("counters moved while a result was waiting");

    a_fire_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> out_free)
        else $error("frame closed into a full result slot");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (!o_valid && !r_in_valid))
        else $error("pipeline not empty after reset");

endmodule
